// ----- design/bb5_pkg.sv -----
// ----------------------------------------------------------------------------
// bb5_pkg: shared types and constants of the 5x5 binomial blur
// Payload structs of both channels, kernel taps, field widths and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bb5_pkg;

  // default frame limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // kernel
  localparam int TAPS = 5;
  localparam logic [2:0] KERNEL [TAPS] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

  // datapath widths
  localparam int PIX_W     = 8;
  localparam int HSUM_W    = 12;
  localparam int VSUM_W    = 16;
  localparam int OUT_SHIFT = 8;

  // row buffers: one slot per row mod 4
  localparam int LINE_SLOTS = 4;
  localparam int SLOT_W     = 2;

  // smallest frame size in use
  localparam int MIN_DIM = 4;

  // configuration registers
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 13;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // item function codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // input request
  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel_in;
  } in_t;

  // result request
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_t;

endpackage

`default_nettype wire

// ----- design/binomial_blur_5x5_replicate.sv -----
// ----------------------------------------------------------------------------
// binomial_blur_5x5_replicate: 5x5 binomial blur with replicated borders
// Horizontal 1-4-6-4-1 pass into four row buffers, vertical pass on read.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : pixel (func 0) or drain (func 1) requests in raster order,
//            accepted when in_valid is high and in_stall is low.
//   out_*  : filtered pixels with row_end / frame_end, taken when out_valid && !out_stall.
//   cfg_*  : frame_width (index 0) and frame_height (index 1); cfg_ready is
//            always high; write only while the block is idle.
// Throughput: one request per clock while in_stall is low. A result passes
//   through the stage register into the output register; spatially the output
//   lags the input by two rows plus two pixels, and 2*width+2 drains end a frame.
// The horizontal sum and buffer access happen at the accepting edge, the
//   vertical sum between the stage register and the output register.
// A stalled receiver holds the output register; the stage register still
//   takes one more result, then in_stall rises until the output drains.
// Reset clears counters, pixel window and both pipeline valids. The row
//   buffers are not cleared: each entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_blur_5x5_replicate import bb5_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // weighted horizontal sum of five taps
  function automatic logic [HSUM_W-1:0] hsum5(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d,
                                              input logic [PIX_W-1:0] e);
    logic [HSUM_W-1:0] acc;
    acc = HSUM_W'(a) * HSUM_W'(KERNEL[0]) + HSUM_W'(b) * HSUM_W'(KERNEL[1])
        + HSUM_W'(c) * HSUM_W'(KERNEL[2]) + HSUM_W'(d) * HSUM_W'(KERNEL[3])
        + HSUM_W'(e) * HSUM_W'(KERNEL[4]);
    return acc;
  endfunction

  // pick one row buffer slot output
  function automatic logic [HSUM_W-1:0] pick_slot(
      input logic [LINE_SLOTS-1:0][HSUM_W-1:0] words,
      input logic [SLOT_W-1:0]                 sel);
    logic [HSUM_W-1:0] word;
    case (sel)
      2'd0:    word = words[0];
      2'd1:    word = words[1];
      2'd2:    word = words[2];
      2'd3:    word = words[3];
      default: word = words[0];
    endcase
    return word;
  endfunction

  // configuration and derived frame size
  logic [FRAME_WIDTH_W-1:0]  frame_width_r;
  logic [FRAME_HEIGHT_W-1:0] frame_height_r;
  logic [WW-1:0]             used_w;
  logic [HW-1:0]             used_h;

  // stream state
  logic [PIX_W-1:0] win_r   [4];
  logic [PIX_W-1:0] win_nxt [4];
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [RW-1:0]    in_row_r, in_row_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;
  logic [RW-1:0]    out_row_r, out_row_nxt;
  logic             drain_r, drain_nxt;

  // accept-side decode
  logic              in_accept;
  logic              emit;
  logic              live;
  logic [RW-1:0]     em_y;
  logic [CW-1:0]     em_x;
  logic [HSUM_W-1:0] hsum;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [CW-1:0]     wr_col;
  logic              em_re;
  logic              em_fe;
  logic              in_frame_done;

  // stage register
  logic              s1_valid_r, s1_valid_nxt;
  logic [RW-1:0]     s1_y_r;
  logic              s1_live_r;
  logic [HSUM_W-1:0] s1_h_r;
  logic              s1_re_r;
  logic              s1_fe_r;
  logic [LINE_SLOTS-1:0][HSUM_W-1:0] rd_data;

  // vertical pass and output register
  logic [VSUM_W-1:0] v_sum;
  logic              out_free;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // saturate frame size to the used range
  always_comb begin
    if (32'(frame_width_r) < 32'(MIN_DIM)) begin
      used_w = WW'(MIN_DIM);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      used_w = WW'(MAX_WIDTH);
    end else begin
      used_w = WW'(frame_width_r);
    end
    if (32'(frame_height_r) < 32'(MIN_DIM)) begin
      used_h = HW'(MIN_DIM);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      used_h = HW'(MAX_HEIGHT);
    end else begin
      used_h = HW'(frame_height_r);
    end
  end

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // horizontal pass, buffer write and counter update
  always_comb begin
    logic          have;
    logic [RW-1:0] hr;
    logic [CW-1:0] hx;
    have          = 1'b0;
    hr            = '0;
    hx            = '0;
    win_nxt       = win_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    drain_nxt     = drain_r;
    emit          = 1'b0;
    live          = 1'b0;
    em_y          = '0;
    em_x          = '0;
    hsum          = '0;
    wr_en         = 1'b0;
    wr_slot       = '0;
    wr_col        = '0;
    in_frame_done = 1'b0;

    if (in_accept) begin
      if (in_data.func == FUNC_DRAIN) begin
        // drain request: flush one pending result
        if (drain_r) begin
          emit = 1'b1;
          em_y = out_row_r;
          em_x = out_col_r;
          if (((HW+1)'(out_row_r) + (HW+1)'(3) <= (HW+1)'(used_h)) &&
              ((WW+1)'(out_col_r) + (WW+1)'(2) >= (WW+1)'(used_w))) begin
            live = 1'b1;
            if (WW'(out_col_r) >= used_w - WW'(1)) begin
              hsum = hsum5(win_r[0], win_r[1], win_r[2], win_r[2], win_r[2]);
            end else begin
              hsum = hsum5(win_r[0], win_r[1], win_r[2], win_r[3], win_r[3]);
            end
          end
          wr_en   = live;
          wr_slot = SLOT_W'(out_row_r[SLOT_W-1:0] + SLOT_W'(2));
          wr_col  = out_col_r;
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          win_nxt[2] = win_r[3];
          win_nxt[3] = '0;
        end
      end else if (!drain_r) begin
        // pixel request
        if (in_col_r >= CW'(2)) begin
          have = 1'b1;
          hr   = in_row_r;
          hx   = CW'(in_col_r - CW'(2));
          if (in_col_r == CW'(2)) begin
            hsum = hsum5(win_r[2], win_r[2], win_r[2], win_r[3], in_data.pixel_in);
          end else if (in_col_r == CW'(3)) begin
            hsum = hsum5(win_r[1], win_r[1], win_r[2], win_r[3], in_data.pixel_in);
          end else begin
            hsum = hsum5(win_r[0], win_r[1], win_r[2], win_r[3], in_data.pixel_in);
          end
        end else if (in_row_r != '0) begin
          // lazy sums of the last two columns of the previous row
          have = 1'b1;
          hr   = RW'(in_row_r - RW'(1));
          hx   = CW'(used_w - WW'(2) + WW'(in_col_r));
          if (in_col_r == CW'(1)) begin
            hsum = hsum5(win_r[0], win_r[1], win_r[2], win_r[2], win_r[2]);
          end else begin
            hsum = hsum5(win_r[0], win_r[1], win_r[2], win_r[3], win_r[3]);
          end
        end

        if (have) begin
          wr_en   = 1'b1;
          wr_slot = hr[SLOT_W-1:0];
          wr_col  = hx;
          if (hr >= RW'(2)) begin
            emit = 1'b1;
            live = 1'b1;
            em_y = RW'(hr - RW'(2));
            em_x = hx;
          end
        end

        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = win_r[3];
        win_nxt[3] = in_data.pixel_in;

        // input position
        if (WW'(in_col_r) >= used_w - WW'(1)) begin
          in_col_nxt = '0;
          if (HW'(in_row_r) >= used_h - HW'(1)) begin
            in_row_nxt    = '0;
            in_frame_done = 1'b1;
          end else begin
            in_row_nxt = RW'(in_row_r + RW'(1));
          end
        end else begin
          in_col_nxt = CW'(in_col_r + CW'(1));
        end
      end
    end

    // output position
    em_re = emit && (WW'(em_x) >= used_w - WW'(1));
    em_fe = em_re && (HW'(em_y) >= used_h - HW'(1));
    if (emit) begin
      if (em_re) begin
        out_col_nxt = '0;
        out_row_nxt = em_fe ? '0 : RW'(em_y + RW'(1));
        if (em_fe) begin
          drain_nxt = 1'b0;
        end
      end else begin
        out_col_nxt = CW'(em_x + CW'(1));
        out_row_nxt = em_y;
      end
    end
    if (in_frame_done) begin
      drain_nxt = 1'b1;
    end
  end

  // row buffer slots
  for (genvar g = 0; g < LINE_SLOTS; g++) begin : g_slot
    bb5_line_ram #(
      .DEPTH (MAX_WIDTH),
      .DW    (HSUM_W)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en && (wr_slot == SLOT_W'(g))),
      .wr_addr (wr_col),
      .wr_data (hsum),
      .rd_en   (emit),
      .rd_addr (em_x),
      .rd_data (rd_data[g])
    );
  end

  // stage and output valids
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (emit) begin
      s1_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= '0;
      end
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      drain_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      drain_r     <= drain_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (emit) begin
      s1_y_r    <= em_y;
      s1_live_r <= live;
      s1_h_r    <= hsum;
      s1_re_r   <= em_re;
      s1_fe_r   <= em_fe;
    end
  end

  // vertical pass over rows y-2 .. y+2, clamped to the frame
  always_comb begin
    logic [RW+1:0]     yk;
    logic [RW+1:0]     tk;
    logic [RW+1:0]     ht_last;
    logic [RW+1:0]     y_top;
    logic [HSUM_W-1:0] tap;
    ht_last = (RW+2)'(used_h) - (RW+2)'(1);
    y_top   = (RW+2)'(s1_y_r) + (RW+2)'(2);
    v_sum   = '0;
    for (int k = 0; k < TAPS; k++) begin
      yk = (RW+2)'(s1_y_r) + (RW+2)'(k);
      tk = (yk < (RW+2)'(2)) ? '0 : yk - (RW+2)'(2);
      if (tk > ht_last) begin
        tk = ht_last;
      end
      if (s1_live_r && (tk == y_top)) begin
        tap = s1_h_r;
      end else begin
        tap = pick_slot(rd_data, tk[SLOT_W-1:0]);
      end
      v_sum = v_sum + VSUM_W'(KERNEL[k]) * VSUM_W'(tap);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r.pixel_out <= v_sum[OUT_SHIFT +: PIX_W];
      out_data_r.row_end   <= s1_re_r;
      out_data_r.frame_end <= s1_fe_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- design/bb5_line_ram.sv -----
// ----------------------------------------------------------------------------
// bb5_line_ram: one row buffer slot
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bb5_line_ram import bb5_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int DW    = HSUM_W
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/bb5_checker.sv -----
// ----------------------------------------------------------------------------
// bb5_checker: port-level checks of the binomial blur
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module bb5_checker import bb5_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  // input stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output request");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output request changed");

  // the last pixel of a frame also ends its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_end) |-> out_data.row_end)
    else $error("frame_end without row_end");

endmodule

bind binomial_blur_5x5_replicate bb5_checker u_bb5_checker (.*);

`default_nettype wire
